>>> rtl/core/plwi_pkg.sv
// Shared types, codes and the channel blend function for the palette lookup block.
package plwi_pkg;

    localparam int CH_W  = 8;
    localparam int OUT_W = 16;
    localparam int POS_W = 16;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_WRITE  = 1'b1;

    typedef struct packed {
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] red;
    } rgb_t;

    typedef struct packed {
        logic [OUT_W-1:0] blue;
        logic [OUT_W-1:0] green;
        logic [OUT_W-1:0] red;
    } blend_t;

    // Computes c0 * 2^fb + (c1 - c0) * f and keeps the low 16 bits.
    function automatic logic [OUT_W-1:0] blend_channel(
        input logic [CH_W-1:0] c0,
        input logic [CH_W-1:0] c1,
        input logic [15:0]     f,
        input int              fb
    );
        logic signed [31:0] base;
        logic signed [31:0] delta;
        logic signed [31:0] sum;
        base  = signed'(32'(c0)) <<< fb;
        delta = (signed'(32'(c1)) - signed'(32'(c0))) * signed'(32'(f));
        sum   = base + delta;
        return sum[OUT_W-1:0];
    endfunction

endpackage

>>> rtl/core/palette_lookup_with_interpolation.sv
// Palette table with linear interpolation between neighboring entries.
//
//   Channel   Direction  tdata (low bit up)                         tuser
//   s_        in         entry, red_in, green_in, blue_in, position  operation
//   m_        out        red_out, green_out, blue_out                -
//
// One item per cycle while m_ is not stalled; a sample result passes the registered
// table read (two ports) and then the blend output register before it appears.
// After reset the table is loaded with a grey ramp, one entry per cycle, and s_tready
// stays low until the last entry is written. A stalled m_ side holds one result in the
// output register and one in the read stage before s_tready drops.
module palette_lookup_with_interpolation
    import plwi_pkg::*;
#(
    parameter int TABLE_ENTRIES = 256,
    parameter int FRACTION_BITS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // entry[7:0], red_in[15:8], green_in[23:16], blue_in[31:24], position[47:32]
    input  logic [47:0] s_tdata,
    // operation[0]
    input  logic [0:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // red_out[15:0], green_out[31:16], blue_out[47:32]
    output logic [47:0] m_tdata
);

    localparam int AW    = $clog2(TABLE_ENTRIES);
    localparam int RW    = AW + 1;
    localparam int DEN   = TABLE_ENTRIES - 1;
    localparam int G_INC = 255 / DEN;
    localparam int R_INC = 255 % DEN;
    localparam int PW    = POS_W + AW;

    localparam logic [RW-1:0]   DEN_R   = RW'(DEN);
    localparam logic [RW-1:0]   R_INC_R = RW'(R_INC);
    localparam logic [CH_W-1:0] G_INC_R = CH_W'(G_INC);
    localparam logic [AW-1:0]   LAST_A  = AW'(TABLE_ENTRIES - 1);

    rgb_t table_mem [TABLE_ENTRIES];

    logic               clr_busy_reg, clr_busy_next;
    logic [AW-1:0]      clr_addr_reg, clr_addr_next;
    logic [CH_W-1:0]    grey_reg, grey_next;
    logic [RW-1:0]      rem_reg, rem_next;
    logic [RW-1:0]      rem_sum;

    logic               s1_valid_reg, s1_valid_next;
    logic [FRACTION_BITS-1:0] frac_reg;
    rgb_t               rd0_reg, rd1_reg;
    logic               out_valid_reg, out_valid_next;
    blend_t             out_data_reg;

    logic               accept;
    logic               sample_acc;
    logic               write_acc;
    logic               s1_advance;
    logic [CH_W-1:0]    in_entry;
    rgb_t               in_color;
    logic [POS_W-1:0]   in_position;
    logic [PW-1:0]      prod;
    logic [AW-1:0]      idx0;
    logic [AW-1:0]      idx1;
    logic [FRACTION_BITS-1:0] frac;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    rgb_t               mem_wdata;
    logic [31:0]        entry_wide;
    blend_t             blend_val;

    assign in_entry       = s_tdata[7:0];
    assign in_color.red   = s_tdata[15:8];
    assign in_color.green = s_tdata[23:16];
    assign in_color.blue  = s_tdata[31:24];
    assign in_position    = s_tdata[47:32];

    assign s1_advance = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready   = !clr_busy_reg && (!s1_valid_reg || s1_advance);
    assign accept     = s_tvalid && s_tready;
    assign sample_acc = accept && (s_tuser[0] == OP_SAMPLE);
    assign entry_wide = 32'(in_entry);
    assign write_acc  = accept && (s_tuser[0] == OP_WRITE)
                        && (entry_wide < 32'(TABLE_ENTRIES));

    assign prod = PW'(in_position) * PW'(TABLE_ENTRIES);
    assign idx0 = prod[POS_W +: AW];
    assign idx1 = (idx0 == LAST_A) ? '0 : idx0 + AW'(1);
    assign frac = prod[POS_W-1 -: FRACTION_BITS];

    always_comb begin
        mem_we    = clr_busy_reg || write_acc;
        mem_waddr = clr_busy_reg ? clr_addr_reg : entry_wide[AW-1:0];
        if (clr_busy_reg) begin
            mem_wdata = '{blue: grey_reg, green: grey_reg, red: grey_reg};
        end else begin
            mem_wdata = in_color;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            table_mem[mem_waddr] <= mem_wdata;
        end
        if (sample_acc) begin
            rd0_reg  <= table_mem[idx0];
            rd1_reg  <= table_mem[idx1];
            frac_reg <= frac;
        end
    end

    // The ramp value round(i * 255 / (N - 1)) advances by a remainder walk.
    assign rem_sum = rem_reg + R_INC_R;

    always_comb begin
        clr_busy_next = clr_busy_reg;
        clr_addr_next = clr_addr_reg;
        grey_next     = grey_reg;
        rem_next      = rem_reg;
        if (clr_busy_reg) begin
            if (clr_addr_reg == LAST_A) begin
                clr_busy_next = 1'b0;
            end else begin
                clr_addr_next = clr_addr_reg + AW'(1);
                if (rem_sum >= DEN_R) begin
                    rem_next  = rem_sum - DEN_R;
                    grey_next = grey_reg + G_INC_R + CH_W'(1);
                end else begin
                    rem_next  = rem_sum;
                    grey_next = grey_reg + G_INC_R;
                end
            end
        end
    end

    always_comb begin
        if (sample_acc) begin
            s1_valid_next = 1'b1;
        end else if (s1_advance) begin
            s1_valid_next = 1'b0;
        end else begin
            s1_valid_next = s1_valid_reg;
        end
        if (s1_advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_comb begin
        blend_val.red   = blend_channel(rd0_reg.red, rd1_reg.red,
                                        16'(frac_reg), FRACTION_BITS);
        blend_val.green = blend_channel(rd0_reg.green, rd1_reg.green,
                                        16'(frac_reg), FRACTION_BITS);
        blend_val.blue  = blend_channel(rd0_reg.blue, rd1_reg.blue,
                                        16'(frac_reg), FRACTION_BITS);
    end

    always_ff @(posedge aclk) begin
        if (s1_advance) begin
            out_data_reg <= blend_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg  <= 1'b1;
            clr_addr_reg  <= '0;
            grey_reg      <= '0;
            rem_reg       <= RW'(DEN / 2);
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            clr_busy_reg  <= clr_busy_next;
            clr_addr_reg  <= clr_addr_next;
            grey_reg      <= grey_next;
            rem_reg       <= rem_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef SYNTHESIS
    a_no_accept_in_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_busy_reg |-> !s_tready)
        else $error("item taken during table fill");

    a_sample_enters_read: assert property (@(posedge aclk) disable iff (!aresetn)
        sample_acc |=> s1_valid_reg)
        else $error("sample item lost before read stage");

    a_read_stage_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && !s1_advance |=> s1_valid_reg)
        else $error("stalled read stage dropped its item");

    a_advance_fills_out: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_advance |=> out_valid_reg)
        else $error("advanced item missing from output register");
`endif

endmodule
